// ===== design/clq_pkg.sv =====
// ----------------------------------------------------------------------------
// clq_pkg: shared types and constants for the calibrated level qualifier
// Sample, register and counter widths, reset values, sample class codes and
// the configuration and result bundles passed between modules.
// ----------------------------------------------------------------------------
package clq_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned OffsetW = 10;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned SumW    = 13;
  localparam int unsigned CalCntW = 3;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;

  // Calibration length: 1 to 7 samples.
  localparam int unsigned CalSamplesDefault = 5;

  // Reciprocal divide: floor(x * ceil(2^k / n) / 2^k) is exact for x < 2^SumW
  // when k = SumW + CalCntW.
  localparam int unsigned DivShift = SumW + CalCntW;
  localparam int unsigned RecipW   = DivShift + 1;

  localparam logic [OffsetW-1:0] LowOffsetReset  = OffsetW'(350);
  localparam logic [OffsetW-1:0] HighOffsetReset = OffsetW'(300);
  localparam logic [LimitW-1:0]  CountLimitReset = LimitW'(30);

  typedef enum logic [1:0] {
    ClassCal  = 2'd0,
    ClassLow  = 2'd1,
    ClassHigh = 2'd2,
    ClassDead = 2'd3
  } class_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLowOffset  = 2'd0,
    CfgHighOffset = 2'd1,
    CfgCountLimit = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OffsetW-1:0] low_offset;
    logic [OffsetW-1:0] high_offset;
    logic [LimitW-1:0]  count_limit;
  } cfg_t;

  typedef struct packed {
    logic   level_flag;
    class_e sample_class;
    logic   burst;
  } result_t;

  // Saturating increment of an event counter.
  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = (v == {CountW{1'b1}}) ? v : v + CountW'(1);
    return r;
  endfunction

endpackage

// ===== design/clq_cfg.sv =====
// ----------------------------------------------------------------------------
// clq_cfg: configuration register file
// Holds the two offsets and the count limit; an accepted write shows on cfg_o from the next cycle.
// ----------------------------------------------------------------------------
module clq_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [clq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [clq_pkg::CfgDataW-1:0]  cfg_data_i,
  output clq_pkg::cfg_t                 cfg_o
);
  import clq_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgLowOffset:  cfg_d.low_offset  = cfg_data_i[OffsetW-1:0];
        CfgHighOffset: cfg_d.high_offset = cfg_data_i[OffsetW-1:0];
        CfgCountLimit: cfg_d.count_limit = cfg_data_i[LimitW-1:0];
        default:       cfg_d = cfg_q;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_offset  <= LowOffsetReset;
      cfg_q.high_offset <= HighOffsetReset;
      cfg_q.count_limit <= CountLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/clq_core.sv =====
// ----------------------------------------------------------------------------
// clq_core: calibration, classification and level qualification
// Holds the running calibration sum, baseline, event counts and level flag;
// all of it advances on step_i and the result for that sample is combinational.
// ----------------------------------------------------------------------------
module clq_core #(
  parameter int unsigned CAL_SAMPLES = clq_pkg::CalSamplesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [clq_pkg::SampleW-1:0]  sample_i,
  input  clq_pkg::cfg_t                cfg_i,
  output clq_pkg::result_t             res_o
);
  import clq_pkg::*;

  localparam logic [CalCntW-1:0] CalTarget = CalCntW'(CAL_SAMPLES);
  localparam logic [RecipW-1:0]  Recip =
      RecipW'(((1 << DivShift) + CAL_SAMPLES - 1) / CAL_SAMPLES);
  localparam int unsigned ProdW = SumW + RecipW;

  logic [SumW-1:0]    cal_sum_q, cal_sum_d;
  logic [CalCntW-1:0] cal_count_q, cal_count_d;
  logic [SampleW-1:0] baseline_q, baseline_d;
  logic [CountW-1:0]  low_count_q, low_count_d;
  logic [CountW-1:0]  high_count_q, high_count_d;
  logic               flag_q, flag_d;

  logic               calibrating;
  logic [SumW-1:0]    sum_next;
  logic [ProdW-1:0]   prod;
  logic signed [SampleW:0] sv, lo_th, hi_th;
  logic               is_low, is_high;
  class_e             cls;

  assign calibrating = cal_count_q < CalTarget;
  assign sum_next    = cal_sum_q + SumW'(sample_i);
  assign prod        = ProdW'(sum_next) * ProdW'(Recip);

  // Thresholds can go negative; compare as 11-bit signed.
  assign sv    = $signed({1'b0, sample_i});
  assign lo_th = $signed({1'b0, baseline_q}) - $signed({1'b0, cfg_i.low_offset});
  assign hi_th = $signed({1'b0, baseline_q}) - $signed({1'b0, cfg_i.high_offset});
  assign is_low  = sv < lo_th;
  assign is_high = !is_low && (sv >= hi_th);

  always_comb begin
    cal_sum_d    = cal_sum_q;
    cal_count_d  = cal_count_q;
    baseline_d   = baseline_q;
    low_count_d  = low_count_q;
    high_count_d = high_count_q;
    flag_d       = flag_q;
    cls          = ClassCal;
    if (calibrating) begin
      cal_sum_d   = sum_next;
      cal_count_d = cal_count_q + CalCntW'(1);
      if (cal_count_d == CalTarget) begin
        baseline_d = prod[DivShift +: SampleW];
      end
    end else begin
      if (is_low) begin
        cls = ClassLow;
        if (!flag_q) low_count_d = sat_inc(low_count_q);
      end else if (is_high) begin
        cls = ClassHigh;
        if (flag_q) high_count_d = sat_inc(high_count_q);
      end else begin
        cls = ClassDead;
      end
      // Qualification runs after counting; low side has priority.
      if (low_count_d > CountW'(cfg_i.count_limit)) begin
        flag_d      = 1'b1;
        low_count_d = '0;
      end else if (high_count_d > CountW'(cfg_i.count_limit)) begin
        flag_d       = 1'b0;
        high_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_sum_q    <= '0;
      cal_count_q  <= '0;
      baseline_q   <= '0;
      low_count_q  <= '0;
      high_count_q <= '0;
      flag_q       <= 1'b0;
    end else if (step_i) begin
      cal_sum_q    <= cal_sum_d;
      cal_count_q  <= cal_count_d;
      baseline_q   <= baseline_d;
      low_count_q  <= low_count_d;
      high_count_q <= high_count_d;
      flag_q       <= flag_d;
    end
  end

  assign res_o.level_flag   = flag_d;
  assign res_o.sample_class = cls;
  assign res_o.burst        = (cls == ClassLow);

  a_cal_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_count_q <= CalTarget)
    else $error("calibration count ran past target");

  a_cal_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && calibrating |-> res_o.sample_class == ClassCal && !res_o.burst)
    else $error("calibration sample was classed");

  a_cal_holds_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && calibrating |=> low_count_q == $past(low_count_q)
                              && high_count_q == $past(high_count_q)
                              && flag_q == $past(flag_q))
    else $error("counts or flag moved during calibration");

endmodule

// ===== design/calibrated_level_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// calibrated_level_qualifier_unit: baseline-calibrated sample level qualifier
//
// Input channel: in_valid_i / in_stall_o with sample_i. A transfer happens on
// a rising edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i with level_flag_o, sample_class_o and burst_o, one result per
// sample. Config channel: cfg_valid_i / cfg_ready_o (always ready) with
// cfg_index_i and cfg_data_i; index 3 is ignored. Write config only when idle.
//
// The sample is held in the input register; when it steps, it is classified,
// the state is updated and the result is written to the result register,
// from which it transfers to the receiver. Throughput is one sample per
// cycle while the receiver does not stall, set by the state update loop
// (counts and level flag feed the next sample).
// While the receiver stalls, the result register holds and the input
// register can still take one more sample; in_stall_o rises only when both
// are full. Reset clears the pipeline, restarts calibration (the first
// CAL_SAMPLES samples report class 0) and loads default register values.
// ----------------------------------------------------------------------------
module calibrated_level_qualifier_unit #(
  parameter int unsigned CAL_SAMPLES = clq_pkg::CalSamplesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [clq_pkg::SampleW-1:0]   sample_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          level_flag_o,
  output logic [1:0]                    sample_class_o,
  output logic                          burst_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [clq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [clq_pkg::CfgDataW-1:0]  cfg_data_i
);
  import clq_pkg::*;

  cfg_t               cfg;
  result_t            res;

  logic               in_valid_q, in_valid_d;
  logic [SampleW-1:0] sample_q;
  logic               out_valid_q, out_valid_d;
  result_t            res_q;

  logic               out_free;   // result register can take a new result
  logic               step;       // sample moves from input reg to result reg
  logic               in_xfer;

  clq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  clq_core #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= sample_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_flag_o   = res_q.level_flag;
  assign sample_class_o = res_q.sample_class;
  assign burst_o        = res_q.burst;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed sample produced no result");

  a_no_step_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !step)
    else $error("result overwritten while receiver stalls");

endmodule
